FILE: design/bsc_pkg.sv
package bsc_pkg;

  localparam int NBITS_DEF   = 1024;
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int INDEX_REACH = 1 << INDEX_W;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  // Store is organized as words of WORD_W bits, scanned one word per cycle
  localparam int WORD_SHIFT = 7;
  localparam int WORD_W     = 1 << WORD_SHIFT;

  localparam int MODE_W = 2;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic scan_step;
    logic result_load;
  } bsc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } bsc_sts_t;

endpackage

FILE: design/bsc_ctrl.sv
module bsc_ctrl
  import bsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  output logic     m_valid,
  input  logic     m_ready,
  input  bsc_sts_t sts,
  output bsc_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_FIN    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   m_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      m_valid <= m_valid_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    m_valid_next = m_valid && !m_ready;
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = ST_FIN;
      end
      // last scanned word is folded into the search results here
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid || m_ready) begin
          cmd.result_load = 1'b1;
          m_valid_next    = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_ready = (state == ST_IDLE);

endmodule

FILE: design/bsc_dp.sv
module bsc_dp
  import bsc_pkg::*;
#(
  parameter int NBITS = NBITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [INDEX_W-1:0] in_index,
  input  bsc_cmd_t           cmd,
  output bsc_sts_t           sts,
  output logic               res_accepted,
  output logic               res_bit_value,
  output logic               res_set_found,
  output logic [INDEX_W-1:0] res_set_index,
  output logic               res_clear_found,
  output logic [INDEX_W-1:0] res_clear_index
);

  localparam int USED_BITS = (NBITS < INDEX_REACH) ? NBITS : INDEX_REACH;
  localparam int DEPTH     = (USED_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = AW + 1;

  function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_SHIFT-1:0] r;
    r = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (v[j]) r = WORD_SHIFT'(j);
    end
    return r;
  endfunction

  logic [COUNT_W-1:0]    bits_in_use;
  logic [COUNT_W-1:0]    n_used;
  logic [CW-1:0]         n_words;

  logic [WORD_W-1:0]     mem [DEPTH];
  logic                  word_vld [DEPTH];
  logic [WORD_W-1:0]     rd_data;
  logic                  rd_vld;
  logic [WORD_W-1:0]     eff_word;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic [MODE_W-1:0]     cur_mode;
  logic [WORD_SHIFT-1:0] cur_pos;
  logic [AW-1:0]         cur_addr;
  logic                  cur_ok;
  logic                  in_ok;
  logic [WORD_W-1:0]     bit_mask;
  logic [WORD_W-1:0]     new_word;
  logic                  wr_en;
  logic                  acc_q;
  logic                  val_q;

  logic [CW-1:0]         scan_cnt;
  logic                  scan_go;
  logic [AW-1:0]         proc_addr;
  logic                  proc_valid;
  logic [COUNT_W-1:0]    base;
  logic [COUNT_W-1:0]    rem;
  logic [WORD_W-1:0]     lim_mask;
  logic [WORD_W-1:0]     set_cand;
  logic [WORD_W-1:0]     clr_cand;
  logic                  set_found;
  logic [INDEX_W-1:0]    set_idx;
  logic                  clr_found;
  logic [INDEX_W-1:0]    clr_idx;

  // effective count: register value clipped to the store size
  assign n_used  = (bits_in_use > COUNT_W'(USED_BITS)) ? COUNT_W'(USED_BITS) : bits_in_use;
  assign n_words = CW'(((COUNT_W + 1)'(n_used) + (COUNT_W + 1)'(WORD_W - 1)) >> WORD_SHIFT);

  assign in_ok   = ({1'b0, in_index} < n_used);
  assign scan_go = cmd.scan_step && (scan_cnt < n_words);
  assign rd_en   = (cmd.capture && in_ok) || scan_go;
  assign rd_addr = cmd.capture ? AW'(in_index >> WORD_SHIFT) : scan_cnt[AW-1:0];

  assign sts.scan_last = ((CW + 1)'(scan_cnt) + (CW + 1)'(1)) >= (CW + 1)'(n_words);

  // never-written words read as zero
  assign eff_word = rd_vld ? rd_data : '0;

  assign bit_mask = WORD_W'(1) << cur_pos;
  always_comb begin
    case (cur_mode)
      MODE_SET:   new_word = eff_word | bit_mask;
      MODE_CLEAR: new_word = eff_word & ~bit_mask;
      default:    new_word = eff_word;
    endcase
  end
  assign wr_en = cmd.update && cur_ok;

  // limit the search to bits below the count in use
  assign base = COUNT_W'(proc_addr) << WORD_SHIFT;
  assign rem  = n_used - base;
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      lim_mask[j] = (COUNT_W'(j) < rem);
    end
  end
  assign set_cand = eff_word & lim_mask;
  assign clr_cand = ~eff_word & lim_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= COUNT_RESET;
      proc_valid  <= 1'b0;
      for (int i = 0; i < DEPTH; i++) word_vld[i] <= 1'b0;
    end else begin
      if (cfg_we) bits_in_use <= cfg_wdata;
      proc_valid <= scan_go;
      if (wr_en) word_vld[cur_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cur_addr] <= new_word;
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= word_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mode  <= in_mode;
      cur_pos   <= in_index[WORD_SHIFT-1:0];
      cur_addr  <= AW'(in_index >> WORD_SHIFT);
      cur_ok    <= in_ok;
      scan_cnt  <= '0;
      set_found <= 1'b0;
      set_idx   <= '0;
      clr_found <= 1'b0;
      clr_idx   <= '0;
    end else begin
      if (scan_go) begin
        scan_cnt  <= scan_cnt + CW'(1);
        proc_addr <= scan_cnt[AW-1:0];
      end
      if (proc_valid) begin
        if (!set_found && (|set_cand)) begin
          set_found <= 1'b1;
          set_idx   <= INDEX_W'(base) | INDEX_W'(lowest_set(set_cand));
        end
        if (!clr_found && (|clr_cand)) begin
          clr_found <= 1'b1;
          clr_idx   <= INDEX_W'(base) | INDEX_W'(lowest_set(clr_cand));
        end
      end
    end
    if (cmd.update) begin
      acc_q <= cur_ok;
      val_q <= cur_ok && new_word[cur_pos];
    end
    if (cmd.result_load) begin
      res_accepted    <= acc_q;
      res_bit_value   <= val_q;
      res_set_found   <= set_found;
      res_set_index   <= set_idx;
      res_clear_found <= clr_found;
      res_clear_index <= clr_idx;
    end
  end

endmodule

FILE: design/bitmap_set_clear_find_first.sv
// Bit store of NBITS bits (at most 1024 reachable) with set, clear and
// find-first-set / find-first-clear. Each transaction reads and updates the
// target word, then scans the words in use one 128-bit word per cycle through
// the single read port of the memory. The store reads as all zeros after
// reset through per-word valid bits; there is no clearing pass. A finished
// result waits in the output register while the next item is accepted.
module bitmap_set_clear_find_first
  import bsc_pkg::*;
#(
  parameter int NBITS = NBITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,       // bits_in_use
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,    // mode[1:0], bit_index[11:2]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // accepted[0], bit_value[1], first_set_found[2], first_set_index[12:3],
  // first_clear_found[13], first_clear_index[23:14]
  output logic [OUT_W-1:0]   m_axis_tdata
);

  bsc_cmd_t           cmd;
  bsc_sts_t           sts;
  logic               res_accepted;
  logic               res_bit_value;
  logic               res_set_found;
  logic [INDEX_W-1:0] res_set_index;
  logic               res_clear_found;
  logic [INDEX_W-1:0] res_clear_index;

  bsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bsc_dp #(
    .NBITS (NBITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (s_axis_tdata[MODE_W-1:0]),
    .in_index        (s_axis_tdata[MODE_W+INDEX_W-1:MODE_W]),
    .cmd             (cmd),
    .sts             (sts),
    .res_accepted    (res_accepted),
    .res_bit_value   (res_bit_value),
    .res_set_found   (res_set_found),
    .res_set_index   (res_set_index),
    .res_clear_found (res_clear_found),
    .res_clear_index (res_clear_index)
  );

  assign m_axis_tdata = {res_clear_index, res_clear_found, res_set_index,
                         res_set_found, res_bit_value, res_accepted};

  // one item in flight: no acceptance right after an acceptance
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous item in progress");

  // an accepted index lies in use, so some bit in use must be found
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2] || m_axis_tdata[13]))
    else $error("accepted item but neither search found a bit");

  // a set bit reported for the item means the set search hits
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1]) |-> m_axis_tdata[2])
    else $error("indexed bit set but no set bit found");

  // a refused item never reports a bit value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !m_axis_tdata[1])
    else $error("refused item reports a set bit");

endmodule

FILE: tb/bitmap_set_clear_find_first_tb.sv
`timescale 1ns / 1ps

module bitmap_set_clear_find_first_tb;
  import bsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STORE_BITS  = (NBITS_DEF < INDEX_REACH) ? NBITS_DEF : INDEX_REACH;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic               accepted;
    logic               bit_value;
    logic               set_found;
    logic [INDEX_W-1:0] set_index;
    logic               clear_found;
    logic [INDEX_W-1:0] clear_index;
  } bitmap_result_t;

  class bitmap_tracker;
    logic [STORE_BITS-1:0] bits = '0;
    logic [COUNT_W-1:0]    count = COUNT_RESET;
    bitmap_result_t        pending_results[$];
    int                    errors = 0;

    function void write_count(logic [COUNT_W-1:0] value);
      count = value;
    endfunction

    // Apply one accepted transaction to the bitmap copy and queue its result
    function void note_item(logic [IN_W-1:0] data);
      mode_t              op;
      logic [INDEX_W-1:0] idx;
      int unsigned        span;
      bitmap_result_t     res;
      op = mode_t'(data[MODE_W-1:0]);
      idx = data[MODE_W +: INDEX_W];
      span = (count > STORE_BITS) ? STORE_BITS : count;
      res = '0;
      if (idx < span) begin
        res.accepted = 1'b1;
        case (op)
          MODE_SET:   bits[idx] = 1'b1;
          MODE_CLEAR: bits[idx] = 1'b0;
          default: ;
        endcase
        res.bit_value = bits[idx];
      end
      for (int k = 0; k < span; k++) begin
        if (bits[k] && !res.set_found) begin
          res.set_found = 1'b1;
          res.set_index = INDEX_W'(k);
        end
        if (!bits[k] && !res.clear_found) begin
          res.clear_found = 1'b1;
          res.clear_index = INDEX_W'(k);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      bitmap_result_t want;
      if (pending_results.size() == 0) begin
        $error("result 0x%0h arrived with no pending transaction", data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("accepted", want.accepted, data[0]);
      check_field("bit_value", want.bit_value, data[1]);
      check_field("first_set_found", want.set_found, data[2]);
      check_field("first_set_index", want.set_index, data[12:3]);
      check_field("first_clear_found", want.clear_found, data[13]);
      check_field("first_clear_index", want.clear_index, data[23:14]);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;   // mode[1:0], bit_index[11:2]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // accepted[0], bit_value[1], first_set_found[2], first_set_index[12:3],
  // first_clear_found[13], first_clear_index[23:14]
  logic [OUT_W-1:0]   m_axis_tdata;

  bitmap_tracker tracker;
  bit            calm = 1'b0;
  int            cycle_count;

  bitmap_set_clear_find_first dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end
  end

  // Result side backpressure
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
    // keep valid high across back-to-back transactions
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({idx, op});
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
  endtask

  // Drop valid, let the last transaction reach the tracker, drain all
  // outstanding results, then write the count
  task automatic start_phase(input logic [COUNT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_count(value);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] value, input int items,
                           input bit idle_ok);
    int unsigned        span;
    int unsigned        set_weight;
    int unsigned        pick;
    logic [MODE_W-1:0]  op;
    logic [INDEX_W-1:0] idx;
    start_phase(value);
    span = (value > STORE_BITS) ? STORE_BITS : value;
    set_weight = $urandom_range(25, 70);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < set_weight) op = MODE_SET;
      else if (pick < set_weight + 15) op = MODE_LOOK;
      else if (pick < set_weight + 20) op = MODE_SPARE;
      else op = MODE_CLEAR;
      // mix wide indices with hits inside the range and near the bottom
      pick = $urandom_range(0, 9);
      if (span == 0 || pick < 3) idx = INDEX_W'($urandom_range(0, INDEX_REACH - 1));
      else if (pick < 6) idx = INDEX_W'($urandom_range(0, span - 1));
      else idx = INDEX_W'($urandom_range(0, ((span < 24) ? span : 24) - 1));
      send_item(op, idx);
      if (idle_ok && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_count;
    int                 phase_items;
    tracker = new();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // top bit reachable with the count left by reset
    send_item(MODE_LOOK, 10'd1023);

    start_phase(11'd1024);
    send_item(MODE_SET, 10'd1023);
    send_item(MODE_LOOK, 10'd1023);
    send_item(MODE_SPARE, 10'd1023);
    send_item(MODE_LOOK, 10'd0);
    send_item(MODE_SET, 10'd0);
    send_item(MODE_CLEAR, 10'd0);
    send_item(MODE_CLEAR, 10'd0);
    send_item(MODE_SET, 10'd512);
    send_item(MODE_CLEAR, 10'd1023);
    send_item(MODE_CLEAR, 10'd512);

    // index equal to the count must be refused
    start_phase(11'd1023);
    send_item(MODE_SET, 10'd1023);
    send_item(MODE_LOOK, 10'd1022);
    send_item(MODE_SET, 10'd1022);

    // fill every used bit so no clear bit is found
    start_phase(11'd3);
    send_item(MODE_SET, 10'd0);
    send_item(MODE_SET, 10'd1);
    send_item(MODE_SET, 10'd2);
    send_item(MODE_SET, 10'd3);
    send_item(MODE_CLEAR, 10'd1);

    start_phase(11'd0);
    send_item(MODE_LOOK, 10'd0);
    send_item(MODE_SET, 10'd0);
    send_item(MODE_CLEAR, 10'd1023);

    // oversized count saturates at the index reach
    start_phase(11'd2047);
    send_item(MODE_SET, 10'd1023);
    send_item(MODE_LOOK, 10'd1023);
    send_item(MODE_CLEAR, 10'd1023);

    for (int p = 0; p < 16; p++) begin
      case (p)
        0:       phase_count = 11'd1;
        1:       phase_count = 11'd2047;
        2:       phase_count = 11'd0;
        3:       phase_count = 11'd128;
        4:       phase_count = 11'd129;
        5:       phase_count = 11'd127;
        6:       phase_count = 11'd8;
        7:       phase_count = COUNT_W'($urandom_range(0, 2047));
        14, 15:  phase_count = 11'd1024;
        default: phase_count = COUNT_W'($urandom_range(1, 1024));
      endcase
      phase_items = (p == 2) ? 40 : 122;
      calm = (p >= 14);
      run_phase(phase_count, phase_items, !calm && $urandom_range(0, 4) != 0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
